### rtl/svzd_pkg.sv
// Shared types and constants for the strict varint / zigzag decoder.
// No dependencies; every other file imports this package.
package svzd_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned LANES    = 10;
    // Wide enough to hold a group at the last lane before truncation.
    localparam int unsigned SHIFT_W  = GROUP_W * LANES;

    localparam logic [INDEX_W-1:0]  LAST_INDEX = INDEX_W'(9);
    localparam logic [7:0]          LAST_MAX   = 8'h01;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONMIN   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       signed_mode;
        logic       stream_end;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] accumulator;
        logic [INDEX_W-1:0] byte_index;
        logic               signed_latched;
    } t_state;

    typedef struct packed {
        logic                emit;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        t_state              next_state;
    } t_step;

endpackage

### rtl/svzd_if.sv
// Valid/ready channel interfaces for the decoder's request and result streams.
// Depends on svzd_pkg for field widths.
interface svzd_req_if import svzd_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       signed_mode;
    logic       stream_end;

    modport source (output valid, output data_byte, output signed_mode,
                    output stream_end, input ready);
    modport sink   (input valid, input data_byte, input signed_mode,
                    input stream_end, output ready);
endinterface

interface svzd_rsp_if import svzd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

### rtl/svzd_step.sv
// Combinational decode of one stream byte against the current varint state.
// Depends on svzd_pkg for the item, state and step types.
module svzd_step import svzd_pkg::*; (
    input  t_item  i_item,
    input  t_state i_state,
    output t_step  o_step
);

    logic [INDEX_W-1:0] idx;
    logic [7:0]         b;
    logic               first;
    logic               overflow;
    logic               cont;
    logic               zz;
    logic [SHIFT_W-1:0] merged;
    logic [VALUE_W-1:0] acc_new;
    logic [VALUE_W-1:0] value_ok;

    assign idx      = i_state.byte_index;
    assign b        = i_item.data_byte;
    assign first    = (idx == '0);
    assign overflow = (idx > LAST_INDEX) || ((idx == LAST_INDEX) && (b > LAST_MAX));
    assign cont     = b[7];
    assign zz       = first ? i_item.signed_mode : i_state.signed_latched;

    // Place the seven payload bits into the lane picked by the index.
    always_comb begin
        merged = {(SHIFT_W - VALUE_W)'(0), i_state.accumulator};
        for (int k = 0; k < LANES; k++) begin
            if (idx == INDEX_W'(k)) begin
                merged[k*GROUP_W +: GROUP_W] = merged[k*GROUP_W +: GROUP_W] | b[6:0];
            end
        end
    end

    assign acc_new  = merged[VALUE_W-1:0];
    assign value_ok = zz ? ((acc_new >> 1) ^ {VALUE_W{acc_new[0]}}) : acc_new;

    always_comb begin
        o_step = '0;
        if (i_item.stream_end) begin
            o_step.emit   = 1'b1;
            o_step.status = ST_TRUNC;
        end else if (overflow) begin
            o_step.emit   = 1'b1;
            o_step.status = ST_OVERFLOW;
        end else if (cont) begin
            // Hold the partial value and advance to the next group.
            o_step.next_state.accumulator    = acc_new;
            o_step.next_state.byte_index     = idx + INDEX_W'(1);
            o_step.next_state.signed_latched = zz;
        end else if (!first && (b == 8'h00)) begin
            o_step.emit   = 1'b1;
            o_step.status = ST_NONMIN;
        end else begin
            o_step.emit   = 1'b1;
            o_step.value  = value_ok;
            o_step.status = ST_OK;
        end
    end

endmodule

### rtl/strict_varint_zigzag_decoder_top.sv
// Strict LEB128 varint decoder with zigzag undo: top level.
// A request passes through the input register, then the result register, before its result is valid.
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// Reset (i_rst_n low, synchronous): drops both stages, clears the decoder state.
// Depends on svzd_pkg, svzd_if and svzd_step.
module strict_varint_zigzag_decoder_top import svzd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svzd_req_if.sink    i_req,
    svzd_rsp_if.source  o_rsp
);

    // Input stage: one registered request waiting to be decoded.
    logic                r_in_valid;
    t_item               r_in;
    // Decoder state carried between bytes of one value.
    t_state              r_state;
    // Result stage.
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0] r_out_status;

    t_step               step;
    logic                out_free;
    logic                go;
    logic                in_ready;

    svzd_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .o_step  (step)
    );

    // The result slot frees when empty or when its result leaves this cycle.
    assign out_free = !r_out_valid || o_rsp.ready;
    // A byte that emits no result needs no result slot, so it never waits on the sink.
    assign go       = r_in_valid && (!step.emit || out_free);
    // The input register refills when empty or when its request retires.
    assign in_ready = !r_in_valid || go;

    assign i_req.ready  = in_ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.status = r_out_status;

    // Input register: take a new request whenever the slot is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in.data_byte   <= i_req.data_byte;
            r_in.signed_mode <= i_req.signed_mode;
            r_in.stream_end  <= i_req.stream_end;
        end
    end

    // Decoder state: advance on every retired byte; any result restarts it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (go) begin
            r_state <= step.next_state;
        end
    end

    // Result register: load on an emitting byte, drop once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && step.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && step.emit) begin
            r_out_value  <= step.value;
            r_out_status <= step.status;
        end
    end

    // The byte index can never pass the tenth group.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_index <= LAST_INDEX)
        else $error("byte index beyond last group");

    // Every error result carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_value == '0))
        else $error("error result with nonzero value");

    // Emitting a result restarts the decoder for the next value.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && step.emit) |=> (r_state == '0))
        else $error("decoder state not cleared after result");

    // A pending result is never overwritten while the sink stalls.
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !(go && step.emit))
        else $error("result register overwritten while stalled");

endmodule
